/* rtl/bloom_filter_seven_hash_macros.svh */
// ----------------------------------------------------------------------------
// bloom filter assertion macros
// checks on one clock with an active low reset; empty under synthesis
// ----------------------------------------------------------------------------
`ifndef BLOOM_FILTER_SEVEN_HASH_MACROS_SVH
`define BLOOM_FILTER_SEVEN_HASH_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BFSH_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("bloom filter check failed");

// next-cycle implication
`define BFSH_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("bloom filter check failed");

`else

`define BFSH_ASSERT_IMPLY(label, clk, rst_n, cond, prop)
`define BFSH_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

/* rtl/bfsh_pkg.sv */
// ----------------------------------------------------------------------------
// bfsh_pkg
// shared types, constants and helpers of the seven-hash bloom filter
// ----------------------------------------------------------------------------
package bfsh_pkg;

    // bit store geometry
    localparam int INDEX_BITS = 20;
    localparam int ROW_BITS   = 5;
    localparam int ROW_WIDTH  = 1 << ROW_BITS;
    localparam int ADDR_BITS  = INDEX_BITS - ROW_BITS;
    localparam int ROW_COUNT  = 1 << ADDR_BITS;

    // hash lanes
    localparam int LANE_COUNT = 7;
    localparam int PROBE_BITS = $clog2(LANE_COUNT);
    localparam int HASH_RS    = 0;
    localparam int HASH_DJB   = 1;
    localparam int HASH_FNV   = 2;
    localparam int HASH_JS    = 3;
    localparam int HASH_PJW   = 4;
    localparam int HASH_SDBM  = 5;
    localparam int HASH_DEK   = 6;

    // hash constants
    localparam logic [31:0] RS_STEP     = 32'd378551;
    localparam logic [31:0] RS_START    = 32'd63689;
    localparam logic [31:0] JS_START    = 32'd1315423911;
    localparam logic [31:0] DJB_START   = 32'd5381;
    localparam logic [31:0] FNV_MULT    = 32'h811C9DC5;
    localparam logic [31:0] PJW_TOP     = 32'hF0000000;
    localparam logic [31:0] PJW_LOW     = 32'h0FFFFFFF;
    localparam int          PJW_SHIFT   = 24;
    localparam int          DEK_ROT     = 5;

    // command codes
    localparam logic CMD_QUERY  = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    // queue between front and back
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
        logic       carries_byte;
        logic       ends_word;
    } in_item_t;

    typedef struct packed {
        logic found;
        logic was_insert;
    } out_item_t;

    typedef struct packed {
        logic                                  command;
        logic [LANE_COUNT-1:0][INDEX_BITS-1:0] index;
    } queue_entry_t;

    typedef struct packed {
        logic         push;
        queue_entry_t entry;
    } q_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_READ,
        BK_CHECK,
        BK_HOLD
    } back_state_t;

    // rotate left by a 5-bit amount
    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] n);
        logic [63:0] tmp;
        tmp = {v, v} << n;
        return tmp[63:32];
    endfunction

    // xor fold of a 32-bit hash down to a store index
    function automatic logic [INDEX_BITS-1:0] fold(input logic [31:0] h);
        logic [31:0] sh;
        sh = h >> INDEX_BITS;
        return h[INDEX_BITS-1:0] ^ sh[INDEX_BITS-1:0];
    endfunction

endpackage

/* rtl/bfsh_stream_if.sv */
// ----------------------------------------------------------------------------
// bfsh_stream_if
// valid/ready channel carrying one request of a given payload type
// ----------------------------------------------------------------------------
interface bfsh_stream_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

/* rtl/bfsh_ram.sv */
// ----------------------------------------------------------------------------
// bfsh_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module bfsh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/bfsh_front.sv */
// ----------------------------------------------------------------------------
// bfsh_front
// accepts word bytes, runs the seven string hashes and queues folded indices
// ----------------------------------------------------------------------------
module bfsh_front (
    input  logic                  clk,
    input  logic                  rst_n,
    bfsh_stream_if.sink           words,
    input  bfsh_pkg::back_status_t back_st,
    input  bfsh_pkg::q_status_t    q_st,
    output bfsh_pkg::q_push_t      push
);

    logic [31:0] hash_reg  [bfsh_pkg::LANE_COUNT];
    logic [31:0] hash_next [bfsh_pkg::LANE_COUNT];
    logic [31:0] absorbed  [bfsh_pkg::LANE_COUNT];
    logic [31:0] rs_mult_reg;
    logic [31:0] rs_mult_next;
    logic [31:0] len_reg;
    logic [31:0] len_next;
    logic [31:0] c;
    logic [31:0] pjw_h;
    logic [31:0] js_h;
    logic [31:0] sdbm_h;
    logic [31:0] dek_seeded;
    logic [4:0]  dek_amt;
    logic        accept;

    // input taken only when the queue has room and the store is ready
    assign words.ready = !q_st.full && !back_st.clearing;
    assign accept      = words.valid && words.ready;
    assign c           = 32'(words.data.data_byte);

    // one byte through every hash
    always_comb
    begin
        pjw_h  = (hash_reg[bfsh_pkg::HASH_PJW] << 4) + c;
        if ((pjw_h & bfsh_pkg::PJW_TOP) != 32'd0)
        begin
            pjw_h = (pjw_h ^ ((pjw_h & bfsh_pkg::PJW_TOP) >> bfsh_pkg::PJW_SHIFT))
                    & bfsh_pkg::PJW_LOW;
        end
        js_h   = hash_reg[bfsh_pkg::HASH_JS];
        sdbm_h = hash_reg[bfsh_pkg::HASH_SDBM];

        absorbed[bfsh_pkg::HASH_RS]   = hash_reg[bfsh_pkg::HASH_RS] * rs_mult_reg + c;
        absorbed[bfsh_pkg::HASH_DJB]  = (hash_reg[bfsh_pkg::HASH_DJB] << 5)
                                        + hash_reg[bfsh_pkg::HASH_DJB] + c;
        absorbed[bfsh_pkg::HASH_FNV]  = (hash_reg[bfsh_pkg::HASH_FNV] * bfsh_pkg::FNV_MULT)
                                        ^ c;
        absorbed[bfsh_pkg::HASH_JS]   = js_h ^ ((js_h << 5) + c + (js_h >> 2));
        absorbed[bfsh_pkg::HASH_PJW]  = pjw_h;
        absorbed[bfsh_pkg::HASH_SDBM] = c + (sdbm_h << 6) + (sdbm_h << 16) - sdbm_h;
        absorbed[bfsh_pkg::HASH_DEK]  = bfsh_pkg::rotl32(hash_reg[bfsh_pkg::HASH_DEK],
                                        5'(bfsh_pkg::DEK_ROT)) ^ c;
    end

    // hashes after this request, byte or no byte
    always_comb
    begin
        for (int i = 0; i < bfsh_pkg::LANE_COUNT; i++)
        begin
            hash_next[i] = words.data.carries_byte ? absorbed[i] : hash_reg[i];
        end
        rs_mult_next = words.data.carries_byte ? rs_mult_reg * bfsh_pkg::RS_STEP
                                               : rs_mult_reg;
        len_next     = words.data.carries_byte ? len_reg + 32'd1 : len_reg;
    end

    // word end: dek length seed folded in, all lanes folded to indices
    always_comb
    begin
        dek_amt    = 5'(len_next[4:0] * 5'd5);
        dek_seeded = hash_next[bfsh_pkg::HASH_DEK] ^ bfsh_pkg::rotl32(len_next, dek_amt);
        push.push          = accept && words.data.ends_word;
        push.entry.command = words.data.command;
        for (int i = 0; i < bfsh_pkg::LANE_COUNT; i++)
        begin
            push.entry.index[i] = bfsh_pkg::fold(hash_next[i]);
        end
        push.entry.index[bfsh_pkg::HASH_DEK] = bfsh_pkg::fold(dek_seeded);
    end

    // hash state, back to start values after each word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bfsh_pkg::LANE_COUNT; i++)
            begin
                hash_reg[i] <= 32'd0;
            end
            hash_reg[bfsh_pkg::HASH_DJB] <= bfsh_pkg::DJB_START;
            hash_reg[bfsh_pkg::HASH_JS]  <= bfsh_pkg::JS_START;
            rs_mult_reg <= bfsh_pkg::RS_START;
            len_reg     <= 32'd0;
        end
        else if (accept)
        begin
            if (words.data.ends_word)
            begin
                for (int i = 0; i < bfsh_pkg::LANE_COUNT; i++)
                begin
                    hash_reg[i] <= 32'd0;
                end
                hash_reg[bfsh_pkg::HASH_DJB] <= bfsh_pkg::DJB_START;
                hash_reg[bfsh_pkg::HASH_JS]  <= bfsh_pkg::JS_START;
                rs_mult_reg <= bfsh_pkg::RS_START;
                len_reg     <= 32'd0;
            end
            else
            begin
                for (int i = 0; i < bfsh_pkg::LANE_COUNT; i++)
                begin
                    hash_reg[i] <= hash_next[i];
                end
                rs_mult_reg <= rs_mult_next;
                len_reg     <= len_next;
            end
        end
    end

endmodule

/* rtl/bfsh_queue.sv */
// ----------------------------------------------------------------------------
// bfsh_queue
// short fifo of finished words between the hashing front and the probe back
// ----------------------------------------------------------------------------
module bfsh_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  bfsh_pkg::q_push_t      push,
    input  logic                   pop,
    output bfsh_pkg::queue_entry_t head,
    output bfsh_pkg::q_status_t    status
);

    bfsh_pkg::queue_entry_t                entries [bfsh_pkg::QUEUE_DEPTH];
    logic [bfsh_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr_reg;
    logic [bfsh_pkg::QUEUE_PTR_BITS-1:0]   rd_ptr_reg;
    logic [bfsh_pkg::QUEUE_CNT_BITS-1:0]   count_reg;
    logic                                  do_push;
    logic                                  do_pop;

    assign status.full  = (count_reg == bfsh_pkg::QUEUE_CNT_BITS'(bfsh_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push.push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = entries[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push.entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == bfsh_pkg::QUEUE_PTR_BITS'(bfsh_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == bfsh_pkg::QUEUE_PTR_BITS'(bfsh_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/bfsh_back.sv */
// ----------------------------------------------------------------------------
// bfsh_back
// clears the bit store after reset, then probes seven bits per queued word
// ----------------------------------------------------------------------------
module bfsh_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  bfsh_pkg::queue_entry_t head,
    input  bfsh_pkg::q_status_t    q_st,
    output logic                   pop,
    output bfsh_pkg::back_status_t status,
    bfsh_stream_if.source          results
);

    bfsh_pkg::back_state_t                 state_reg;
    bfsh_pkg::back_state_t                 state_next;
    logic [bfsh_pkg::ADDR_BITS-1:0]        clear_row_reg;
    logic [bfsh_pkg::ADDR_BITS-1:0]        clear_row_next;
    logic [bfsh_pkg::PROBE_BITS-1:0]       probe_reg;
    logic [bfsh_pkg::PROBE_BITS-1:0]       probe_next;
    logic                                  found_reg;
    logic                                  found_next;
    logic                                  out_valid_reg;
    logic                                  out_valid_next;
    bfsh_pkg::out_item_t                   out_data_reg;
    bfsh_pkg::out_item_t                   out_data_next;

    logic [bfsh_pkg::INDEX_BITS-1:0]       cur_index;
    logic [bfsh_pkg::ADDR_BITS-1:0]        cur_row;
    logic [bfsh_pkg::ROW_BITS-1:0]         cur_bit;
    logic                                  out_free;
    logic                                  last_probe;

    logic                                  wr_en;
    logic [bfsh_pkg::ADDR_BITS-1:0]        wr_addr;
    logic [bfsh_pkg::ROW_WIDTH-1:0]        wr_data;
    logic                                  rd_en;
    logic [bfsh_pkg::ROW_WIDTH-1:0]        rd_data;

    bfsh_ram #(
        .WIDTH (bfsh_pkg::ROW_WIDTH),
        .DEPTH (bfsh_pkg::ROW_COUNT)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (cur_row),
        .rd_data (rd_data)
    );

    // current probe position in the store
    assign cur_index  = head.index[probe_reg];
    assign cur_row    = cur_index[bfsh_pkg::INDEX_BITS-1:bfsh_pkg::ROW_BITS];
    assign cur_bit    = cur_index[bfsh_pkg::ROW_BITS-1:0];
    assign last_probe = (probe_reg == bfsh_pkg::PROBE_BITS'(bfsh_pkg::LANE_COUNT - 1));
    assign out_free   = !out_valid_reg || results.ready;

    assign status.clearing = (state_reg == bfsh_pkg::BK_CLEAR);
    assign results.valid   = out_valid_reg;
    assign results.data    = out_data_reg;

    // next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        clear_row_next = clear_row_reg;
        probe_next     = probe_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_data_next  = out_data_reg;
        pop            = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = cur_row;
        wr_data        = rd_data | (bfsh_pkg::ROW_WIDTH'(1) << cur_bit);
        rd_en          = 1'b0;

        unique case (state_reg)
            bfsh_pkg::BK_CLEAR:
            begin
                wr_en          = 1'b1;
                wr_addr        = clear_row_reg;
                wr_data        = '0;
                clear_row_next = clear_row_reg + 1'b1;
                if (&clear_row_reg)
                begin
                    state_next = bfsh_pkg::BK_IDLE;
                end
            end
            bfsh_pkg::BK_IDLE:
            begin
                probe_next = '0;
                found_next = 1'b1;
                if (!q_st.empty)
                begin
                    state_next = bfsh_pkg::BK_READ;
                end
            end
            bfsh_pkg::BK_READ:
            begin
                rd_en      = 1'b1;
                state_next = bfsh_pkg::BK_CHECK;
            end
            bfsh_pkg::BK_CHECK:
            begin
                // read-modify-write for insert, and-reduce for query
                wr_en      = (head.command == bfsh_pkg::CMD_INSERT);
                found_next = found_reg && rd_data[cur_bit];
                if (!last_probe)
                begin
                    probe_next = probe_reg + 1'b1;
                    state_next = bfsh_pkg::BK_READ;
                end
                else if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.found      = (head.command == bfsh_pkg::CMD_QUERY)
                                               && found_next;
                    out_data_next.was_insert = head.command;
                    pop                      = 1'b1;
                    state_next               = bfsh_pkg::BK_IDLE;
                end
                else
                begin
                    state_next = bfsh_pkg::BK_HOLD;
                end
            end
            bfsh_pkg::BK_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.found      = (head.command == bfsh_pkg::CMD_QUERY)
                                               && found_reg;
                    out_data_next.was_insert = head.command;
                    pop                      = 1'b1;
                    state_next               = bfsh_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = bfsh_pkg::BK_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfsh_pkg::BK_CLEAR;
            clear_row_reg <= '0;
            probe_reg     <= '0;
            found_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clear_row_reg <= clear_row_next;
            probe_reg     <= probe_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

/* rtl/bloom_filter_seven_hash.sv */
// bytes are taken one per cycle unless the queue is full or the store is clearing;
// a byte that does not end a word gives no result; a word end gives its result
// once the back has picked up the queued word and made seven store probes, each a
// read and then a check or read-modify-write on the single ram port pair; words
// queue two deep behind it; after reset the 32-bit wide store is cleared row by
// row, all 32768 rows, with ready low before the first byte is taken
// ----------------------------------------------------------------------------
// bloom_filter_seven_hash
// seven-hash bloom filter over a byte stream with insert and query commands
// ----------------------------------------------------------------------------
`include "bloom_filter_seven_hash_macros.svh"

module bloom_filter_seven_hash (
    input  logic          clk,
    input  logic          rst_n,
    bfsh_stream_if.sink   words,
    bfsh_stream_if.source results
);

    bfsh_pkg::q_push_t      q_push;
    bfsh_pkg::q_status_t    q_st;
    bfsh_pkg::queue_entry_t q_head;
    bfsh_pkg::back_status_t back_st;
    logic                   q_pop;

    // hashing front
    bfsh_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .words   (words),
        .back_st (back_st),
        .q_st    (q_st),
        .push    (q_push)
    );

    // word queue
    bfsh_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .pop    (q_pop),
        .head   (q_head),
        .status (q_st)
    );

    // store probing back
    bfsh_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (q_head),
        .q_st    (q_st),
        .pop     (q_pop),
        .status  (back_st),
        .results (results)
    );

    // cross-module checks
    `BFSH_ASSERT_IMPLY(a_push_not_full, clk, rst_n, q_push.push, !q_st.full)
    `BFSH_ASSERT_IMPLY(a_pop_not_empty, clk, rst_n, q_pop, !q_st.empty)
    `BFSH_ASSERT_NEXT(a_pop_gives_result, clk, rst_n, q_pop, results.valid)
    `BFSH_ASSERT_IMPLY(a_no_input_while_clearing, clk, rst_n, back_st.clearing, !words.ready)

endmodule
